@@ design/center_of_mass_frame_shift_macros.svh @@
// Assertion macros for the checker of center_of_mass_frame_shift.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CENTER_OF_MASS_FRAME_SHIFT_MACROS_SVH
`define CENTER_OF_MASS_FRAME_SHIFT_MACROS_SVH

// same-cycle implication
`define COMFS_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define COMFS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/comfs_pkg.sv @@
// Shared constants, beat types, controller types and helpers for the
// center-of-mass frame shift block. No dependencies.
package comfs_pkg;

  localparam int MAX_BODIES = 64;
  localparam int BODY_AW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);

  localparam int MASS_IN_W  = 16;
  localparam int DATA_W     = 32;
  localparam int MASS_W     = 22;
  localparam int PROD_W     = MASS_IN_W + DATA_W;
  localparam int SUM_W      = 54;
  // weighted mean stays within the range of the inputs: one extra bit
  localparam int COM_W      = DATA_W + 1;
  localparam int NUM_AXES   = 3;
  localparam int NUM_OPS    = 2 * NUM_AXES;
  localparam int OP_W       = $clog2(NUM_OPS);
  localparam int DIV_STEP_W = $clog2(SUM_W);

  typedef struct packed {
    logic [MASS_IN_W-1:0]     body_mass;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic                     final_body;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rel_pos_x;
    logic signed [DATA_W-1:0] rel_pos_y;
    logic signed [DATA_W-1:0] rel_pos_z;
    logic signed [DATA_W-1:0] rel_vel_x;
    logic signed [DATA_W-1:0] rel_vel_y;
    logic signed [DATA_W-1:0] rel_vel_z;
    logic                     last_out;
    logic                     zero_mass;
    logic                     overflowed;
  } out_beat_t;

  typedef enum logic [6:0] {
    S_LOAD      = 7'b0000001,
    S_ACC       = 7'b0000010,
    S_DIV_ISSUE = 7'b0000100,
    S_DIV_WAIT  = 7'b0001000,
    S_RD        = 7'b0010000,
    S_FILL      = 7'b0100000,
    S_SEND      = 7'b1000000
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_capture;
    logic com_zero;
    logic rd_first;
    logic rd_next;
    logic fill;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mass_zero;
    logic count_zero;
    logic div_done;
    logic op_last;
    logic body_last;
  } ctrl_stat_t;

  // clamp a difference of two 33-bit values into 32 bits
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W-1:0] r;
    if ((v[DATA_W+1:DATA_W-1] == 3'b000) || (v[DATA_W+1:DATA_W-1] == 3'b111)) begin
      r = v[DATA_W-1:0];
    end else if (v[DATA_W+1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ design/comfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module comfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/comfs_div.sv @@
// Restoring divider, one quotient bit per cycle, signed dividend by unsigned
// divisor, truncating toward zero. Depends on comfs_pkg.
module comfs_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [comfs_pkg::SUM_W-1:0] dividend,
  input  logic [comfs_pkg::MASS_W-1:0]     divisor,
  output logic                             done,
  output logic signed [comfs_pkg::SUM_W-1:0] quotient
);
  import comfs_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [MASS_W-1:0]     rem;
  logic [SUM_W-1:0]      quo;
  logic                  neg;
  logic [MASS_W-1:0]     dvsr;
  logic [MASS_W:0]       shifted;
  logic [MASS_W+1:0]     trial;
  logic                  fits;
  logic                  step_last;

  assign shifted   = {rem, quo[SUM_W-1]};
  assign trial     = {1'b0, shifted} - {2'b00, dvsr};
  assign fits      = !trial[MASS_W+1];
  assign step_last = (step == DIV_STEP_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && step_last;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step_last) begin
          busy <= 1'b0;
        end
        step <= step + DIV_STEP_W'(1);
      end
    end
  end

  // quo starts as the dividend magnitude and fills with quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
      neg  <= dividend[SUM_W-1];
      dvsr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[MASS_W-1:0] : shifted[MASS_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

@@ design/comfs_dp.sv @@
// Datapath: body stores, weighted-sum accumulators, divider, center-of-mass
// registers and the output register. Depends on comfs_pkg, comfs_ram, comfs_div.
module comfs_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  comfs_pkg::in_beat_t    body,
  input  comfs_pkg::ctrl_cmd_t   cmd,
  output comfs_pkg::ctrl_stat_t  stat,
  output comfs_pkg::out_beat_t   result
);
  import comfs_pkg::*;

  logic [CNT_W-1:0]           count;
  logic [MASS_W-1:0]          mass_total;
  logic                       overflow_seen;
  logic                       full;
  logic                       store_en;
  logic signed [DATA_W-1:0]   in_vals [NUM_OPS];
  logic signed [PROD_W-1:0]   prod_next [NUM_OPS];
  logic signed [PROD_W-1:0]   prods [NUM_OPS];
  logic                       prod_valid;
  logic signed [SUM_W-1:0]    sums [NUM_OPS];
  logic signed [COM_W-1:0]    com [NUM_OPS];
  logic [OP_W-1:0]            op_idx;
  logic [BODY_AW-1:0]         idx;
  logic [BODY_AW-1:0]         raddr;
  logic                       re;
  logic [NUM_AXES*DATA_W-1:0] pos_wdata, vel_wdata, pos_rdata, vel_rdata;
  logic signed [DATA_W-1:0]   stored [NUM_OPS];
  logic signed [DATA_W-1:0]   rel [NUM_OPS];
  logic                       div_done;
  logic signed [SUM_W-1:0]    quotient;
  logic signed [MASS_IN_W:0]  mass_s;

  assign full     = (count == CNT_W'(MAX_BODIES));
  assign store_en = cmd.accept && !full;
  assign mass_s   = signed'({1'b0, body.body_mass});

  always_comb begin
    in_vals[0] = body.pos_x;
    in_vals[1] = body.pos_y;
    in_vals[2] = body.pos_z;
    in_vals[3] = body.vel_x;
    in_vals[4] = body.vel_y;
    in_vals[5] = body.vel_z;
    for (int a = 0; a < NUM_OPS; a++) begin
      prod_next[a] = PROD_W'(mass_s) * PROD_W'(in_vals[a]);
    end
  end

  assign pos_wdata = {body.pos_z, body.pos_y, body.pos_x};
  assign vel_wdata = {body.vel_z, body.vel_y, body.vel_x};

  comfs_ram #(.WIDTH(NUM_AXES * DATA_W), .DEPTH(MAX_BODIES)) u_pos_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (count[BODY_AW-1:0]),
    .wdata (pos_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (pos_rdata)
  );

  comfs_ram #(.WIDTH(NUM_AXES * DATA_W), .DEPTH(MAX_BODIES)) u_vel_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (count[BODY_AW-1:0]),
    .wdata (vel_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (vel_rdata)
  );

  // products are registered, then added into the sums in the next cycle
  always_ff @(posedge clk) begin
    if (store_en) begin
      for (int a = 0; a < NUM_OPS; a++) begin
        prods[a] <= prod_next[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      prod_valid    <= 1'b0;
      count         <= '0;
      mass_total    <= '0;
      overflow_seen <= 1'b0;
      op_idx        <= '0;
      for (int a = 0; a < NUM_OPS; a++) begin
        sums[a] <= '0;
      end
    end else begin
      prod_valid <= store_en;
      if (prod_valid) begin
        for (int a = 0; a < NUM_OPS; a++) begin
          sums[a] <= sums[a] + SUM_W'(prods[a]);
        end
      end
      if (cmd.accept) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          count      <= count + CNT_W'(1);
          mass_total <= mass_total + MASS_W'(body.body_mass);
        end
      end
      if (cmd.div_capture) begin
        op_idx <= op_idx + OP_W'(1);
      end
    end
  end

  comfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sums[op_idx]),
    .divisor  (mass_total),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.com_zero) begin
      for (int a = 0; a < NUM_OPS; a++) begin
        com[a] <= '0;
      end
    end else if (cmd.div_capture) begin
      com[op_idx] <= quotient[COM_W-1:0];
    end
  end

  // read side of the stores
  assign re    = cmd.rd_first || cmd.rd_next;
  assign raddr = cmd.rd_next ? (idx + BODY_AW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      idx <= '0;
    end else if (cmd.rd_next) begin
      idx <= idx + BODY_AW'(1);
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      stored[a]            = pos_rdata[a*DATA_W +: DATA_W];
      stored[a + NUM_AXES] = vel_rdata[a*DATA_W +: DATA_W];
    end
    for (int a = 0; a < NUM_OPS; a++) begin
      rel[a] = sat_data((DATA_W+2)'(stored[a]) - (DATA_W+2)'(com[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      result.rel_pos_x  <= rel[0];
      result.rel_pos_y  <= rel[1];
      result.rel_pos_z  <= rel[2];
      result.rel_vel_x  <= rel[3];
      result.rel_vel_y  <= rel[4];
      result.rel_vel_z  <= rel[5];
      result.last_out   <= stat.body_last;
      result.zero_mass  <= stat.mass_zero;
      result.overflowed <= overflow_seen;
    end
  end

  always_comb begin
    stat.mass_zero  = (mass_total == '0);
    stat.count_zero = (count == '0);
    stat.div_done   = div_done;
    stat.op_last    = (op_idx == OP_W'(NUM_OPS - 1));
    stat.body_last  = ((CNT_W'(idx) + CNT_W'(1)) == count);
  end

endmodule

@@ design/comfs_ctrl.sv @@
// Controller state machine: load phase, division sequence, emission.
// Depends on comfs_pkg.
module comfs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  body_valid,
  input  logic                  body_final,
  output logic                  body_stall,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  comfs_pkg::ctrl_stat_t stat,
  output comfs_pkg::ctrl_cmd_t  cmd
);
  import comfs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign body_stall   = (state != S_LOAD);
  assign result_valid = (state == S_SEND);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (body_valid) begin
          cmd.accept = 1'b1;
          if (body_final) begin
            state_next = S_ACC;
          end
        end
      end
      // last product lands in the sums at the end of this cycle
      S_ACC: begin
        if (stat.mass_zero) begin
          cmd.com_zero = 1'b1;
          state_next   = S_RD;
        end else begin
          state_next = S_DIV_ISSUE;
        end
      end
      S_DIV_ISSUE: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_capture = 1'b1;
          state_next      = stat.op_last ? S_RD : S_DIV_ISSUE;
        end
      end
      S_RD: begin
        if (stat.count_zero) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill   = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (!result_stall) begin
          if (stat.body_last) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = S_FILL;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

@@ design/center_of_mass_frame_shift.sv @@
// Center-of-mass frame shift. Bodies are loaded one beat per cycle; each one
// that finds a free slot is written to the position and velocity stores and
// its mass-weighted position and velocity are added into six running sums.
// The beat marked final_body (stored or, when all MAX_BODIES slots are taken,
// dropped) closes the set: once the last product has reached the sums, the six
// sums are divided by the total mass, one after the other on a single shared
// divider at one quotient bit per cycle (skipped when the total mass is zero).
// Every stored body is then sent in load order, each result beat passing
// through a registered store read and then the output register. No body is
// taken from the end of the final beat until the last result beat is taken.
// Depends on comfs_pkg, comfs_ctrl, comfs_dp.
module center_of_mass_frame_shift (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 body_valid,
  output logic                 body_stall,
  input  comfs_pkg::in_beat_t  body,
  output logic                 result_valid,
  input  logic                 result_stall,
  output comfs_pkg::out_beat_t result
);
  import comfs_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  comfs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .body_valid   (body_valid),
    .body_final   (body.final_body),
    .body_stall   (body_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  comfs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .body   (body),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

@@ design/comfs_chk.sv @@
// Port-level checker for center_of_mass_frame_shift, bound to the top level.
// Depends on comfs_pkg and center_of_mass_frame_shift_macros.svh.
`include "center_of_mass_frame_shift_macros.svh"

module comfs_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 body_valid,
  input logic                 body_stall,
  input comfs_pkg::in_beat_t  body,
  input logic                 result_valid,
  input logic                 result_stall,
  input comfs_pkg::out_beat_t result
);

  logic res_wait;
  logic res_take;
  logic body_take;

  assign res_wait  = result_valid && result_stall;
  assign res_take  = result_valid && !result_stall;
  assign body_take = body_valid && !body_stall;

  // a stalled result beat holds
  `COMFS_NEXT(a_result_hold, res_wait, result_valid && $stable(result), "stalled beat changed")

  // no body is taken while results are being sent
  `COMFS_HOLDS(a_no_load_in_emit, result_valid, body_stall, "body accepted during emission")

  // the last beat of a set ends the emission
  `COMFS_NEXT(a_last_ends, res_take && result.last_out, !result_valid, "result after last beat")

  // a body that does not close the set yields no result
  `COMFS_NEXT(a_nonfinal_quiet, body_take && !body.final_body, !result_valid, "unexpected result")

endmodule

bind center_of_mass_frame_shift comfs_chk u_comfs_chk (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for center_of_mass_frame_shift: directed body sets, then random sets
// under several idle/stall mixes, each result beat checked against an in-bench frame model
// or a typed-in expectation. Depends on comfs_pkg and the center_of_mass_frame_shift RTL.
module tb_top;
  import comfs_pkg::*;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
  localparam int HOLD_CYCLES     = 600;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int TAIL_CYCLES     = 64;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      body_valid = 1'b0;
  logic      body_stall;
  in_beat_t  body = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_beat_t result;

  // sideband that travels with the offered beat: typed-in expectation
  bit        typed_row = 1'b0;
  out_beat_t typed_want = '0;

  int stall_pct = 0;
  int sender_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // frame model state
  longint    pos_mem [MAX_BODIES][NUM_AXES];
  longint    vel_mem [MAX_BODIES][NUM_AXES];
  longint    wpos_sum [NUM_AXES];
  longint    wvel_sum [NUM_AXES];
  longint    mass_sum = 0;
  int        bodies_held = 0;
  bit        dropped_any = 1'b0;
  out_beat_t shifted_q [$];

  dir_row_t  dir_rows [$];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sets_closed = 0;
  int overflow_sets = 0;
  int zero_sets = 0;
  int saturated = 0;

  center_of_mass_frame_shift i_dut (
    .clk          (clk),
    .rst          (rst),
    .body_valid   (body_valid),
    .body_stall   (body_stall),
    .body         (body),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > 64'sh7FFFFFFF) return Q_MAX;
    if (v < -64'sh80000000) return Q_MIN;
    return 32'(v);
  endfunction

  function automatic in_beat_t mk_body(input logic [15:0] m,
                                       input logic [31:0] px, py, pz, vx, vy, vz,
                                       input bit fin);
    in_beat_t b;
    b.body_mass  = m;
    b.pos_x      = px;
    b.pos_y      = py;
    b.pos_z      = pz;
    b.vel_x      = vx;
    b.vel_y      = vy;
    b.vel_z      = vz;
    b.final_body = fin;
    return b;
  endfunction

  function automatic out_beat_t mk_result(input logic [31:0] px, py, pz, vx, vy, vz,
                                          input bit lst, zm, ov);
    out_beat_t r;
    r.rel_pos_x  = px;
    r.rel_pos_y  = py;
    r.rel_pos_z  = pz;
    r.rel_vel_x  = vx;
    r.rel_vel_y  = vy;
    r.rel_vel_z  = vz;
    r.last_out   = lst;
    r.zero_mass  = zm;
    r.overflowed = ov;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4, 5: return $urandom_range(32'h001FFFFF) - 32'h00100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_mass();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(255, 1));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Accumulate one accepted body; on the closing beat, compute the center of mass
  // and queue one shifted beat per stored body, or the typed-in beat for a typed row.
  task automatic predict_shift(input in_beat_t b, input bit typed, input out_beat_t want);
    longint    m;
    longint    p [NUM_AXES];
    longint    v [NUM_AXES];
    longint    com_p [NUM_AXES];
    longint    com_v [NUM_AXES];
    longint    d [NUM_OPS];
    logic [31:0] c [NUM_OPS];
    out_beat_t r;
    int        a, n;
    m    = longint'(b.body_mass);
    p[0] = longint'($signed(b.pos_x));
    p[1] = longint'($signed(b.pos_y));
    p[2] = longint'($signed(b.pos_z));
    v[0] = longint'($signed(b.vel_x));
    v[1] = longint'($signed(b.vel_y));
    v[2] = longint'($signed(b.vel_z));
    if (bodies_held < MAX_BODIES) begin
      for (a = 0; a < NUM_AXES; a++) begin
        pos_mem[bodies_held][a] = p[a];
        vel_mem[bodies_held][a] = v[a];
        wpos_sum[a] += m * p[a];
        wvel_sum[a] += m * v[a];
      end
      mass_sum += m;
      bodies_held++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!b.final_body) return;

    // signed division truncates toward zero
    for (a = 0; a < NUM_AXES; a++) begin
      com_p[a] = (mass_sum != 0) ? wpos_sum[a] / mass_sum : 0;
      com_v[a] = (mass_sum != 0) ? wvel_sum[a] / mass_sum : 0;
    end
    for (n = 0; n < bodies_held; n++) begin
      for (a = 0; a < NUM_AXES; a++) begin
        d[a]            = pos_mem[n][a] - com_p[a];
        d[NUM_AXES + a] = vel_mem[n][a] - com_v[a];
      end
      for (a = 0; a < NUM_OPS; a++) begin
        c[a] = clamp32(d[a]);
        if (longint'($signed(c[a])) != d[a]) saturated++;
      end
      r = mk_result(c[0], c[1], c[2], c[3], c[4], c[5],
                    n == bodies_held - 1, mass_sum == 0, dropped_any);
      if (!typed) shifted_q.push_back(r);
    end
    if (typed) shifted_q.push_back(want);

    sets_closed++;
    if (dropped_any) overflow_sets++;
    if (mass_sum == 0) zero_sets++;
    for (a = 0; a < NUM_AXES; a++) begin
      wpos_sum[a] = 0;
      wvel_sum[a] = 0;
    end
    mass_sum    = 0;
    bodies_held = 0;
    dropped_any = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (shifted_q.size() == 0) begin
      $error("result beat with no shifted body pending");
      mismatches++;
      return;
    end
    want = shifted_q.pop_front();
    compare_field("rel_pos_x", want.rel_pos_x, got.rel_pos_x);
    compare_field("rel_pos_y", want.rel_pos_y, got.rel_pos_y);
    compare_field("rel_pos_z", want.rel_pos_z, got.rel_pos_z);
    compare_field("rel_vel_x", want.rel_vel_x, got.rel_vel_x);
    compare_field("rel_vel_y", want.rel_vel_y, got.rel_vel_y);
    compare_field("rel_vel_z", want.rel_vel_z, got.rel_vel_z);
    compare_field("last_out", want.last_out, got.last_out);
    compare_field("zero_mass", want.zero_mass, got.zero_mass);
    compare_field("overflowed", want.overflowed, got.overflowed);
    results_seen++;
  endtask

  // both handshakes sampled with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (body_valid && !body_stall) predict_shift(body, typed_row, typed_want);
      if (result_valid && !result_stall) check_result(result);
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic offer_body(input in_beat_t b, input bit typed, input out_beat_t want);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      body_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    body       <= b;
    typed_row  <= typed;
    typed_want <= want;
    body_valid <= 1'b1;
    @(posedge clk);
    while (body_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    body_valid <= 1'b0;
    @(negedge clk);
    while (shifted_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // shape 0: full store at maximum mass; shape 1: overflowing set, final beat dropped
  task automatic send_random_set(input int shape);
    int       len, k, r;
    bit       zero_set;
    in_beat_t b;
    r = $urandom_range(99);
    if (shape == 0) len = MAX_BODIES;
    else if (shape == 1) len = MAX_BODIES + 6;
    else if (r < 60) len = $urandom_range(6, 1);
    else if (r < 85) len = $urandom_range(24, 7);
    else if (r < 95) len = $urandom_range(MAX_BODIES, 25);
    else len = $urandom_range(MAX_BODIES + 8, MAX_BODIES + 1);
    zero_set = (shape > 1) && ($urandom_range(9) == 0);
    for (k = 0; k < len; k++) begin
      b = mk_body(zero_set ? 16'h0000 : rand_mass(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(), k == len - 1);
      if (shape == 0) begin
        b.body_mass = 16'hFFFF;
        b.pos_x     = Q_MIN;
        b.pos_y     = Q_MAX;
      end
      offer_body(b, 1'b0, '0);
    end
  endtask

  task automatic add_row(input in_beat_t b, input bit typed, input out_beat_t want);
    dir_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  initial begin
    int i, phase, phase_start, set_no;

    // single-body sets: the center of mass is the body itself
    add_row(mk_body(16'd1, 1, 2, 3, -1, -2, -3, 1'b1), 1'b1,
            mk_result(0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0));
    add_row(mk_body(16'hFFFF, Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, -1, 1'b1), 1'b1,
            mk_result(0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0));
    // zero total mass: passed through unshifted
    add_row(mk_body(16'h0000, Q_MAX, Q_MIN, 5, -7, Q_MIN, Q_MAX, 1'b1), 1'b1,
            mk_result(Q_MAX, Q_MIN, 5, -7, Q_MIN, Q_MAX, 1'b1, 1'b1, 1'b0));
    add_row(mk_body(16'h0000, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
            mk_result(0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    // opposite extremes, heavy body pulls the center: light one saturates
    add_row(mk_body(16'd1, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0), 1'b0, '0);
    add_row(mk_body(16'hFFFF, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1), 1'b0, '0);
    // negative mean rounds toward zero
    add_row(mk_body(16'd1, -3, -3, 3, 3, -1, 1, 1'b0), 1'b0, '0);
    add_row(mk_body(16'd1, 0, 0, 0, 0, 0, 0, 1'b1), 1'b0, '0);
    // multi-body zero-mass set
    add_row(mk_body(16'h0000, 100, -200, 300, -400, 500, -600, 1'b0), 1'b0, '0);
    add_row(mk_body(16'h0000, Q_MIN, Q_MAX, 0, Q_MAX, 0, Q_MIN, 1'b0), 1'b0, '0);
    add_row(mk_body(16'h0000, -1, 1, -1, 1, -1, 1, 1'b1), 1'b0, '0);
    // mixed masses, one massless body inside a weighted set
    add_row(mk_body(16'd7, 32'h00010000, 32'hFFFF0000, 32'h00008000, 1, 2, 3, 1'b0), 1'b0, '0);
    add_row(mk_body(16'h0000, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0), 1'b0, '0);
    add_row(mk_body(16'd300, -5000, 7000, -9000, 11, -13, 17, 1'b0), 1'b0, '0);
    add_row(mk_body(16'h8000, 32'h12345678, 32'h87654321, 32'hAAAA5555, 32'h5555AAAA,
                    32'h0F0F0F0F, 32'hF0F0F0F0, 1'b1), 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < dir_rows.size(); i++)
      offer_body(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    set_no = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
        1: begin sender_idle_pct = 77; stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  stall_pct <= 77; end
        default: begin sender_idle_pct = 36; stall_pct <= 36; end
      endcase
      // long output hold-off while bodies keep coming: input must back up
      if (phase == 0) hold_req <= hold_req + 1;
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        send_random_set(set_no);
        set_no++;
      end
      wait_drained();
    end

    stall_pct <= 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d body beats in %0d sets, %0d shifted beats checked.",
             items_sent, sets_closed, results_seen);
    $display("Sets with dropped bodies: %0d, zero total mass: %0d, clamped fields: %0d.",
             overflow_sets, zero_sets, saturated);
    if (mismatches == 0 && shifted_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
